// File: rtl/elsc_pkg.sv
// ============================================================================
// elsc_pkg
// Shared types and constants for the event lifecycle state checker.
// ============================================================================
package elsc_pkg;

    localparam int GEN_W       = 16;
    localparam int CNT_W       = 16;
    localparam int OP_W        = 3;
    localparam int IDX_FIELD_W = 10;

    // Record table depth; the index field is reduced to the low IDX_W bits.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int GEN_INIT_DEF = 1;
    localparam int GEN_MAX_DEF  = 65535;

    // Slave word: opcode, event_index, handle_generation, zero fill.
    localparam int S_OP_LSB   = 0;
    localparam int S_IDX_LSB  = S_OP_LSB + OP_W;
    localparam int S_HGEN_LSB = S_IDX_LSB + IDX_FIELD_W;
    localparam int S_USED_W   = S_HGEN_LSB + GEN_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Master word: result_index, new_generation, count_error,
    // generation_error, free_count, send_count, zero fill.
    localparam int M_USED_W  = IDX_FIELD_W + GEN_W + 2 + 2 * CNT_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INIT        = 3'd0,
        OP_INIT_EXT    = 3'd1,
        OP_ALLOC       = 3'd2,
        OP_FREE        = 3'd3,
        OP_TO_USER     = 3'd4,
        OP_TO_USER_REV = 3'd5,
        OP_TO_RT       = 3'd6,
        OP_TO_RT_REV   = 3'd7
    } op_t;

    typedef struct packed {
        logic        [GEN_W-1:0] gen;
        logic signed [CNT_W-1:0] scnt;
        logic signed [CNT_W-1:0] fcnt;
    } rec_t;

endpackage

// File: rtl/event_lifecycle_state_checker_top.sv
// ============================================================================
// event_lifecycle_state_checker_top
// Per-event lifecycle record table with count and generation checks.
// ============================================================================
// Usage:
//   s_* carries one operation word per handshake (opcode, event_index,
//   handle_generation); m_* returns exactly one result word per operation,
//   in order. cfg_wen/cfg_wdata write prealloc_mode; the user must do so
//   only while the block is idle, as the block itself has no check for it.
//   An accepted operation word is registered in the update stage, and its
//   result word then in the output register that drives m_*.
//   Throughput: one word per cycle unless m_tready stalls. Each word is one
//   read-modify-write of its record in the record memory (registered read);
//   a record written in the same cycle as the next word reads is forwarded.
//   Reset: prealloc_mode clears and, once rst_n rises, a clearing pass
//   zeroes all TABLE_DEPTH (1024) entries of the record memory, one entry
//   per cycle. s_tready stays low for the whole pass.
//   Stall: the output register holds its word while m_tready is low; one
//   more word can wait in the update stage, then s_tready drops.
// ============================================================================
module event_lifecycle_state_checker_top #(
    parameter int GEN_INIT = elsc_pkg::GEN_INIT_DEF,
    parameter int GEN_MAX  = elsc_pkg::GEN_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: opcode[2:0], event_index[12:3], handle_generation[28:13], zero fill
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [elsc_pkg::S_TDATA_W-1:0] s_tdata,
    // tdata: result_index[9:0], new_generation[25:10], count_error[26],
    //        generation_error[27], free_count[43:28], send_count[59:44], zero fill
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [elsc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_wen,
    input  logic                           cfg_wdata
);
    import elsc_pkg::*;

    localparam logic [GEN_W-1:0] GEN_INIT_V = GEN_W'(GEN_INIT);
    localparam logic [GEN_W-1:0] GEN_MAX_V  = GEN_W'(GEN_MAX);
    localparam logic [IDX_W-1:0] CLR_LAST   = IDX_W'(TABLE_DEPTH - 1);

    rec_t mem [TABLE_DEPTH];

    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic             mode_reg;

    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [GEN_W-1:0] s1_hgen_reg;
    rec_t             rd_reg;
    logic             fwd_hit_reg;
    rec_t             fwd_rec_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_tdata_reg;

    op_t              in_op;
    logic [IDX_W-1:0] in_idx;
    logic             in_acc;
    logic             s1_adv;

    rec_t                    cur_rec;
    rec_t                    new_rec;
    logic        [GEN_W-1:0] gen_inc;
    logic        [GEN_W-1:0] gen_up;
    logic signed [CNT_W-1:0] exp_f;
    logic signed [CNT_W-1:0] exp_s;
    logic                    chk_cnt;
    logic                    cnt_err;
    logic                    gen_err;

    assign in_op  = op_t'(s_tdata[S_OP_LSB +: OP_W]);
    assign in_idx = s_tdata[S_IDX_LSB +: IDX_W];

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign in_acc   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;

    // Clearing pass and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_wen)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // Record memory: one write port (clear or update), one registered read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (s1_adv)
        begin
            mem[s1_idx_reg] <= new_rec;
        end
        if (in_acc)
        begin
            rd_reg <= mem[in_idx];
        end
    end

    // Update stage payload; forward the record being written this cycle
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_op_reg   <= in_op;
            s1_idx_reg  <= in_idx;
            s1_hgen_reg <= s_tdata[S_HGEN_LSB +: GEN_W];
            fwd_hit_reg <= s1_adv && (s1_idx_reg == in_idx);
            fwd_rec_reg <= new_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_tdata_reg <= {(M_TDATA_W - M_USED_W)'(0), new_rec.scnt, new_rec.fcnt,
                              gen_err, cnt_err, new_rec.gen, IDX_FIELD_W'(s1_idx_reg)};
        end
    end

    assign cur_rec = fwd_hit_reg ? fwd_rec_reg : rd_reg;
    assign gen_inc = cur_rec.gen + 1'b1;
    // Keep the incremented generation from reaching the maximum
    assign gen_up  = (gen_inc == GEN_MAX_V) ? GEN_INIT_V : gen_inc;

    always_comb
    begin
        new_rec = cur_rec;
        exp_f   = '0;
        exp_s   = '0;
        chk_cnt = 1'b1;
        gen_err = 1'b0;
        case (s1_op_reg)
            OP_INIT:
            begin
                new_rec = '{gen: GEN_INIT_V, scnt: '0, fcnt: '0};
                chk_cnt = 1'b0;
            end
            OP_INIT_EXT:
            begin
                new_rec = '{gen: GEN_INIT_V, scnt: CNT_W'(1), fcnt: '0};
                chk_cnt = 1'b0;
            end
            OP_ALLOC:
            begin
                if (mode_reg)
                begin
                    new_rec.fcnt = cur_rec.fcnt - 1'b1;
                end
                else
                begin
                    new_rec = '{gen: GEN_INIT_V, scnt: '0, fcnt: '0};
                    chk_cnt = 1'b0;
                end
            end
            OP_FREE:
            begin
                new_rec.fcnt = cur_rec.fcnt + 1'b1;
                new_rec.gen  = gen_up;
                exp_f        = CNT_W'(1);
                gen_err      = (s1_hgen_reg != cur_rec.gen);
            end
            OP_TO_USER:
            begin
                new_rec.scnt = cur_rec.scnt - 1'b1;
            end
            OP_TO_USER_REV:
            begin
                new_rec.scnt = cur_rec.scnt + 1'b1;
                exp_s        = CNT_W'(1);
            end
            OP_TO_RT:
            begin
                new_rec.scnt = cur_rec.scnt + 1'b1;
                new_rec.gen  = gen_up;
                exp_s        = CNT_W'(1);
                gen_err      = (s1_hgen_reg != cur_rec.gen);
            end
            OP_TO_RT_REV:
            begin
                new_rec.scnt = cur_rec.scnt - 1'b1;
                new_rec.gen  = cur_rec.gen - 1'b1;
                gen_err      = (s1_hgen_reg != new_rec.gen);
            end
            default:
            begin
                new_rec = cur_rec;
            end
        endcase
        cnt_err = chk_cnt && ((new_rec.fcnt != exp_f) || (new_rec.scnt != exp_s));
    end

endmodule

// File: rtl/elsc_checker.sv
// ============================================================================
// elsc_checker
// Port-level checks for the event lifecycle state checker.
// ============================================================================
module elsc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [elsc_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // An accepted word is followed by a valid output word after the update stage and output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("no result word after accepted operation");

    // The clearing pass blocks input right after reset
    a_clear_block: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready)
        else $error("input accepted before clearing pass");

    // Reset leaves no pending result
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result word pending after reset");

endmodule

bind event_lifecycle_state_checker_top elsc_checker u_elsc_checker (.*);

// File: verif/event_lifecycle_state_checker_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// event_lifecycle_state_checker_top_tb
// This testbench sends lifecycle operation words into the checker and checks
// every result word field by field against a model of the record table kept
// in this file. The run has a short hand-written sequence in both allocation
// modes, then random lifecycle traffic with idle and stall bursts on both
// streams, and then steady runs that push the free and send counts away
// from their expected values in both directions.
// ============================================================================
module event_lifecycle_state_checker_top_tb;

    import elsc_pkg::*;

    localparam logic [GEN_W-1:0] GEN_INIT_V = GEN_W'(GEN_INIT_DEF);
    localparam logic [GEN_W-1:0] GEN_MAX_V  = GEN_W'(GEN_MAX_DEF);
    localparam int               SHOWN_MAX  = 40;

    // One operation word as it sits in s_tdata, opcode in the low bits.
    typedef struct packed {
        logic [GEN_W-1:0]       handle_generation;
        logic [IDX_FIELD_W-1:0] event_index;
        op_t                    opcode;
    } lifecycle_op_t;

    // One result word as it sits in m_tdata, result_index in the low bits.
    typedef struct packed {
        logic [M_TDATA_W-M_USED_W-1:0] fill;
        logic [CNT_W-1:0]              send_count;
        logic [CNT_W-1:0]              free_count;
        logic                          generation_error;
        logic                          count_error;
        logic [GEN_W-1:0]              new_generation;
        logic [IDX_FIELD_W-1:0]        result_index;
    } result_word_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wen   = 1'b0;
    logic                 cfg_wdata = 1'b0;

    lifecycle_op_t    pending_ops[$];
    result_word_t     expected_results[$];
    rec_t             event_table[TABLE_DEPTH];
    logic [GEN_W-1:0] planned_gen[TABLE_DEPTH];
    bit               prealloc_setting;
    bit               calm;

    int  mismatch_count;
    int  ops_accepted;
    int  results_checked;
    int  src_idle_pct;
    int  sink_idle_pct;
    int  src_gap;
    int  sink_stall;
    int  src_cycles;
    int  sink_cycles;
    bit  word_taken;

    lifecycle_op_t taken_op;
    result_word_t  got_word;
    result_word_t  want_word;

    event_lifecycle_state_checker_top #(
        .GEN_INIT (GEN_INIT_DEF),
        .GEN_MAX  (GEN_MAX_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [GEN_W-1:0] gen_step_up(logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + 1'b1;
        if (n == GEN_MAX_V)
            n = GEN_INIT_V;
        return n;
    endfunction

    // Read-modify-write one record and build the result word it produces.
    function automatic result_word_t apply_lifecycle_op(lifecycle_op_t item);
        int               slot;
        rec_t             rec;
        logic [GEN_W-1:0] prior_gen;
        logic [CNT_W-1:0] want_free;
        logic [CNT_W-1:0] want_send;
        bit               counts_checked;
        bit               gen_bad;
        result_word_t     res;
        slot           = item.event_index % TABLE_DEPTH;
        rec            = event_table[slot];
        prior_gen      = rec.gen;
        want_free      = '0;
        want_send      = '0;
        counts_checked = 1'b1;
        gen_bad        = 1'b0;
        res            = '0;
        case (item.opcode)
            OP_INIT:
            begin
                rec.gen = GEN_INIT_V; rec.fcnt = '0; rec.scnt = '0;
                counts_checked = 1'b0;
            end
            OP_INIT_EXT:
            begin
                rec.gen = GEN_INIT_V; rec.fcnt = '0; rec.scnt = 16'sd1;
                counts_checked = 1'b0;
            end
            OP_ALLOC:
            begin
                if (!prealloc_setting)
                begin
                    rec.gen = GEN_INIT_V; rec.fcnt = '0; rec.scnt = '0;
                    counts_checked = 1'b0;
                end
                else
                begin
                    rec.fcnt = rec.fcnt - 16'sd1;
                end
            end
            OP_FREE:
            begin
                rec.fcnt  = rec.fcnt + 16'sd1;
                rec.gen   = gen_step_up(prior_gen);
                want_free = 16'd1;
                gen_bad   = (item.handle_generation != prior_gen);
            end
            OP_TO_USER:
            begin
                rec.scnt = rec.scnt - 16'sd1;
            end
            OP_TO_USER_REV:
            begin
                rec.scnt  = rec.scnt + 16'sd1;
                want_send = 16'd1;
            end
            OP_TO_RT:
            begin
                rec.scnt  = rec.scnt + 16'sd1;
                rec.gen   = gen_step_up(prior_gen);
                want_send = 16'd1;
                gen_bad   = (item.handle_generation != prior_gen);
            end
            default:
            begin
                // revert of hand to runtime: no wrap rule on the way down
                rec.scnt = rec.scnt - 16'sd1;
                rec.gen  = prior_gen - 1'b1;
                gen_bad  = (item.handle_generation != rec.gen);
            end
        endcase
        event_table[slot]    = rec;
        res.result_index     = IDX_FIELD_W'(slot);
        res.new_generation   = rec.gen;
        res.count_error      = counts_checked
                               && (rec.fcnt != want_free || rec.scnt != want_send);
        res.generation_error = gen_bad;
        res.free_count       = rec.fcnt;
        res.send_count       = rec.scnt;
        return res;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 12;
            default: return 35;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < SHOWN_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Queue one word and track the generation a caller's handle would carry.
    task automatic queue_op(input op_t op, input logic [IDX_FIELD_W-1:0] idx,
                            input logic [GEN_W-1:0] hgen);
        lifecycle_op_t item;
        int            slot;
        item.opcode            = op;
        item.event_index       = idx;
        item.handle_generation = hgen;
        slot                   = idx % TABLE_DEPTH;
        pending_ops.push_back(item);
        case (op)
            OP_INIT, OP_INIT_EXT: planned_gen[slot] = GEN_INIT_V;
            OP_ALLOC:
            begin
                if (!prealloc_setting)
                    planned_gen[slot] = GEN_INIT_V;
            end
            OP_FREE, OP_TO_RT:    planned_gen[slot] = gen_step_up(planned_gen[slot]);
            OP_TO_RT_REV:         planned_gen[slot] = planned_gen[slot] - 1'b1;
            default:              ;
        endcase
    endtask

    // Mostly whole lifecycles on a few hot records, the rest noise anywhere.
    task automatic queue_random_ops(input int count);
        int                     queued;
        int                     steps;
        op_t                    op;
        logic [IDX_FIELD_W-1:0] idx;
        logic [GEN_W-1:0]       hgen;
        queued = 0;
        while (queued < count)
        begin
            if ($urandom_range(99) < 20)
            begin
                idx  = IDX_FIELD_W'($urandom_range(1023));
                hgen = ($urandom_range(3) == 0) ? planned_gen[idx] : GEN_W'($urandom);
                queue_op(op_t'($urandom_range(7)), idx, hgen);
                queued++;
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    idx = IDX_FIELD_W'($urandom_range(1023));
                else if ($urandom_range(1) == 0)
                    idx = IDX_FIELD_W'($urandom_range(15));
                else
                    idx = IDX_FIELD_W'(1008 + $urandom_range(15));
                queue_op(op_t'($urandom_range(2)), idx, GEN_W'($urandom));
                steps = $urandom_range(1, 6);
                repeat (steps)
                begin
                    op   = op_t'($urandom_range(3, 7));
                    hgen = (op == OP_TO_RT_REV) ? planned_gen[idx] - 1'b1
                                                : planned_gen[idx];
                    if ($urandom_range(9) == 0)
                        hgen = GEN_W'($urandom);
                    queue_op(op, idx, hgen);
                end
                queued += steps + 1;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_prealloc(input bit mode);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        prealloc_setting = mode;
    endtask

    // Operation word driver: predict on acceptance, present at falling edge.
    always
    begin
        @(posedge clk);
        word_taken = s_tvalid && s_tready;
        if (word_taken)
        begin
            taken_op = pending_ops.pop_front();
            expected_results.push_back(apply_lifecycle_op(taken_op));
            ops_accepted++;
        end
        @(negedge clk);
        src_cycles++;
        if (calm)
            src_idle_pct = 0;
        else if (src_cycles % 200 == 0)
            src_idle_pct = pick_idle_pct();
        if (s_tvalid && !word_taken)
            ; // hold the word until it is taken
        else if (src_gap > 0)
        begin
            src_gap--;
            s_tvalid <= 1'b0;
        end
        else if (pending_ops.size() != 0 && $urandom_range(99) < src_idle_pct)
        begin
            src_gap = $urandom_range(4);
            s_tvalid <= 1'b0;
        end
        else if (pending_ops.size() != 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {{(S_TDATA_W - S_USED_W){1'b0}}, pending_ops[0]};
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Result word monitor and receiver stalls.
    always
    begin
        @(posedge clk);
        if (m_tvalid && m_tready)
        begin
            got_word = m_tdata;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with nothing expected", m_tdata));
            end
            else
            begin
                want_word = expected_results.pop_front();
                if (got_word.result_index !== want_word.result_index)
                    report_mismatch($sformatf("result_index got %0d want %0d",
                        got_word.result_index, want_word.result_index));
                if (got_word.new_generation !== want_word.new_generation)
                    report_mismatch($sformatf("new_generation got %h want %h",
                        got_word.new_generation, want_word.new_generation));
                if (got_word.count_error !== want_word.count_error)
                    report_mismatch($sformatf("count_error got %b want %b",
                        got_word.count_error, want_word.count_error));
                if (got_word.generation_error !== want_word.generation_error)
                    report_mismatch($sformatf("generation_error got %b want %b",
                        got_word.generation_error, want_word.generation_error));
                if (got_word.free_count !== want_word.free_count)
                    report_mismatch($sformatf("free_count got %h want %h",
                        got_word.free_count, want_word.free_count));
                if (got_word.send_count !== want_word.send_count)
                    report_mismatch($sformatf("send_count got %h want %h",
                        got_word.send_count, want_word.send_count));
            end
            results_checked++;
        end
        @(negedge clk);
        sink_cycles++;
        if (calm)
            sink_idle_pct = 0;
        else if (sink_cycles % 200 == 100)
            sink_idle_pct = pick_idle_pct();
        if (sink_stall > 0)
        begin
            sink_stall--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(99) < sink_idle_pct)
        begin
            sink_stall = $urandom_range(4);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            event_table[i] = '0;
            planned_gen[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // hold off until the clearing pass is done
        while (!s_tready)
            @(posedge clk);
        write_prealloc(1'b0);

        // fresh record, full hand-off cycle, bad handle, counts off
        queue_op(OP_FREE,        10'd0,    16'h0000);
        queue_op(OP_INIT_EXT,    10'd3,    16'hFFFF);
        queue_op(OP_TO_USER,     10'd3,    16'h0000);
        queue_op(OP_TO_USER_REV, 10'd3,    16'h0000);
        queue_op(OP_TO_USER,     10'd3,    16'h0000);
        queue_op(OP_TO_RT,       10'd3,    16'h0001);
        queue_op(OP_TO_RT_REV,   10'd3,    16'h0001);
        queue_op(OP_TO_RT,       10'd3,    16'h5555);
        queue_op(OP_TO_RT,       10'd3,    16'h0002);
        // walk the generation down past zero, then wrap it up through GEN_MAX
        queue_op(OP_ALLOC,       10'd1023, 16'hAAAA);
        queue_op(OP_TO_RT_REV,   10'd1023, 16'h0000);
        queue_op(OP_TO_RT_REV,   10'd1023, 16'hFFFF);
        queue_op(OP_TO_RT,       10'd1023, 16'hFFFF);
        queue_op(OP_TO_RT_REV,   10'd1023, 16'hFFFF);
        queue_op(OP_TO_RT_REV,   10'd1023, 16'hFFFE);
        queue_op(OP_TO_RT,       10'd1023, 16'hFFFE);
        queue_op(OP_INIT,        10'd512,  16'h0000);
        queue_op(OP_TO_RT_REV,   10'd512,  16'h0000);
        queue_op(OP_TO_RT_REV,   10'd512,  16'hFFFF);
        queue_op(OP_TO_RT_REV,   10'd512,  16'hFFFE);
        queue_op(OP_FREE,        10'd512,  16'hFFFE);
        wait_drained();

        write_prealloc(1'b1);
        queue_op(OP_ALLOC,       10'd512,  16'h0000);
        queue_op(OP_ALLOC,       10'd0,    16'h0000);
        queue_op(OP_ALLOC,       10'd0,    16'hFFFF);
        queue_op(OP_INIT,        10'd0,    16'h0000);
        queue_op(OP_FREE,        10'd0,    16'h0001);
        wait_drained();

        queue_random_ops(850);
        wait_drained();
        write_prealloc(1'b0);
        queue_random_ops(850);
        wait_drained();

        // no idling from here on; run send count upward, free count below zero
        calm = 1'b1;
        queue_op(OP_INIT, 10'd100, 16'h0000);
        repeat (40) queue_op(OP_TO_USER_REV, 10'd100, 16'h0000);
        wait_drained();
        write_prealloc(1'b1);
        queue_op(OP_INIT, 10'd200, 16'h0000);
        repeat (40) queue_op(OP_ALLOC, 10'd200, 16'h0000);
        queue_random_ops(60);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Ran %0d operation words and checked %0d result words,", ops_accepted,
            results_checked);
        $display("both allocation modes, generation wrap and counts run far off in both ways.");
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(50_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: event_lifecycle_state_checker_top.f
rtl/elsc_pkg.sv
rtl/event_lifecycle_state_checker_top.sv
rtl/elsc_checker.sv
verif/event_lifecycle_state_checker_top_tb.sv
